// ----- src/hmw_pkg.sv -----
// shared types and constants of the health monitor watchdog
package hmw_pkg;

    // operation codes of an input item
    localparam logic [1:0] OP_INIT    = 2'd0;
    localparam logic [1:0] OP_KICK    = 2'd1;
    localparam logic [1:0] OP_PUBLISH = 2'd2;
    localparam logic [1:0] OP_CHECK   = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_TIMEOUT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUS_STALL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PUBLISH_STALE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_WARN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOD_PERCENT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TRANS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RECENT_ERROR  = 3'd6;

    // configuration reset values
    localparam logic [31:0] RST_LOOP_TIMEOUT  = 32'd30000;
    localparam logic [31:0] RST_BUS_STALL     = 32'd10000;
    localparam logic [31:0] RST_PUBLISH_STALE = 32'd300000;
    localparam logic [23:0] RST_HEAP_WARN     = 24'd20480;
    localparam logic [6:0]  RST_FLOOD_PERCENT = 7'd80;
    localparam logic [31:0] RST_MIN_TRANS     = 32'd100;
    localparam logic [31:0] RST_RECENT_ERROR  = 32'd30000;

    // percentage scale of the flood test
    localparam logic [6:0] PCT_SCALE = 7'd100;
    localparam int unsigned PROD_W = 40;

    // one input item
    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] now_ms;
        logic [31:0] stored_reboots;
        logic        bus_active;
        logic        link_connected;
        logic [31:0] transactions;
        logic [31:0] errors;
        logic [31:0] last_error_ms;
        logic [23:0] heap_free;
    } t_item_in;

    // one result item
    typedef struct packed {
        logic        reboot_request;
        logic        bus_reset;
        logic        link_reconnect;
        logic        error_flood;
        logic        heap_low;
        logic [31:0] reboot_total;
    } t_item_out;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic eval;
        logic commit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic is_check;
    } t_sts;

endpackage

// ----- src/hmw_in_if.sv -----
// input item channel
interface hmw_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] now_ms;
    logic [31:0] stored_reboots;
    logic        bus_active;
    logic        link_connected;
    logic [31:0] transactions;
    logic [31:0] errors;
    logic [31:0] last_error_ms;
    logic [23:0] heap_free;

    modport source (
        output valid, operation, now_ms, stored_reboots, bus_active, link_connected,
               transactions, errors, last_error_ms, heap_free,
        input  ready
    );
    modport sink (
        input  valid, operation, now_ms, stored_reboots, bus_active, link_connected,
               transactions, errors, last_error_ms, heap_free,
        output ready
    );
endinterface

// ----- src/hmw_out_if.sv -----
// result item channel
interface hmw_out_if;
    logic        valid;
    logic        ready;
    logic        reboot_request;
    logic        bus_reset;
    logic        link_reconnect;
    logic        error_flood;
    logic        heap_low;
    logic [31:0] reboot_total;

    modport source (
        output valid, reboot_request, bus_reset, link_reconnect, error_flood,
               heap_low, reboot_total,
        input  ready
    );
    modport sink (
        input  valid, reboot_request, bus_reset, link_reconnect, error_flood,
               heap_low, reboot_total,
        output ready
    );
endinterface

// ----- src/hmw_cfg_if.sv -----
// configuration write channel
interface hmw_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- src/health_monitor_watchdog.sv -----
// Health monitor watchdog: loop, bus, publish, error flood and heap checks.
// A check item is captured, evaluated and then committed to the result register;
// init, kick and publish items go straight from capture to commit.
// Items are taken only in the idle state, so one item is in flight at a time;
// a result left waiting holds off the commit.
// Reset (synchronous, active low) restores the register defaults and clears state.
module health_monitor_watchdog
    import hmw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    hmw_in_if.sink      i_in,
    hmw_out_if.source   o_out,
    hmw_cfg_if.sink     i_cfg
);

    t_cmd      cmd;
    t_sts      sts;
    t_item_in  item;
    t_item_out result;
    logic      in_ready;
    logic      out_valid;

    // pack the input transfer
    assign item.operation      = i_in.operation;
    assign item.now_ms         = i_in.now_ms;
    assign item.stored_reboots = i_in.stored_reboots;
    assign item.bus_active     = i_in.bus_active;
    assign item.link_connected = i_in.link_connected;
    assign item.transactions   = i_in.transactions;
    assign item.errors         = i_in.errors;
    assign item.last_error_ms  = i_in.last_error_ms;
    assign item.heap_free      = i_in.heap_free;
    assign i_in.ready          = in_ready;

    // config writes always taken
    assign i_cfg.ready = 1'b1;

    hmw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    hmw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_item      (item),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_result    (result)
    );

    // unpack the result
    assign o_out.valid          = out_valid;
    assign o_out.reboot_request = result.reboot_request;
    assign o_out.bus_reset      = result.bus_reset;
    assign o_out.link_reconnect = result.link_reconnect;
    assign o_out.error_flood    = result.error_flood;
    assign o_out.heap_low       = result.heap_low;
    assign o_out.reboot_total   = result.reboot_total;

endmodule

// ----- src/hmw_ctrl.sv -----
// sequencing controller of the health monitor watchdog
module hmw_ctrl
    import hmw_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       accept;
    logic       commit;

    // handshake and commands
    assign o_in_ready   = (r_state == S_IDLE);
    assign accept       = i_in_valid && o_in_ready;
    assign commit       = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_cmd.load   = accept;
    assign o_cmd.eval   = (r_state == S_EVAL);
    assign o_cmd.commit = commit;
    assign o_out_valid  = r_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_sts.is_check ? S_EVAL : S_DONE;
                end
            end
            S_EVAL: n_state = S_DONE;
            S_DONE: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output register occupancy
    always_comb begin
        n_out_valid = r_out_valid;
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- src/hmw_dp.sv -----
// datapath of the health monitor watchdog: config, timers, tests, result register
module hmw_dp
    import hmw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  t_item_in             i_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output t_item_out            o_result
);

    // configuration registers
    logic [31:0] r_loop_timeout;
    logic [31:0] r_bus_stall;
    logic [31:0] r_publish_stale;
    logic [23:0] r_heap_warn;
    logic [6:0]  r_flood_percent;
    logic [31:0] r_min_trans;
    logic [31:0] r_recent_error;

    // watchdog state
    logic        r_enabled;
    logic [31:0] r_kick_time;
    logic [31:0] r_publish_time;
    logic [31:0] r_busy_since;
    logic [31:0] r_reboot_count;

    // captured item and evaluation results
    t_item_in    r_item;
    logic        r_loop_fail;
    logic        r_bus_rst;
    logic        r_stale;
    logic        r_trans_gt;
    logic        r_recent;
    logic        r_heap_low;
    logic [PROD_W-1:0] r_err_prod;
    logic [PROD_W-1:0] r_thr_prod;
    t_item_out   r_result;

    logic        n_loop_fail;
    logic        n_bus_rst;
    logic        n_stale;
    logic [32:0] err_total;
    logic [7:0]  flood_plus1;
    logic [PROD_W-1:0] n_err_prod;
    logic [PROD_W-1:0] n_thr_prod;
    logic        flood;
    t_item_out   n_result;

    assign o_sts.is_check = (i_item.operation == OP_CHECK);
    assign o_result       = r_result;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_timeout  <= RST_LOOP_TIMEOUT;
            r_bus_stall     <= RST_BUS_STALL;
            r_publish_stale <= RST_PUBLISH_STALE;
            r_heap_warn     <= RST_HEAP_WARN;
            r_flood_percent <= RST_FLOOD_PERCENT;
            r_min_trans     <= RST_MIN_TRANS;
            r_recent_error  <= RST_RECENT_ERROR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LOOP_TIMEOUT:  r_loop_timeout  <= i_cfg_data;
                REG_BUS_STALL:     r_bus_stall     <= i_cfg_data;
                REG_PUBLISH_STALE: r_publish_stale <= i_cfg_data;
                REG_HEAP_WARN:     r_heap_warn     <= i_cfg_data[23:0];
                REG_FLOOD_PERCENT: r_flood_percent <= i_cfg_data[6:0];
                REG_MIN_TRANS:     r_min_trans     <= i_cfg_data;
                REG_RECENT_ERROR:  r_recent_error  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
    end

    // timer tests, wrapping differences
    assign n_loop_fail = (r_item.now_ms - r_kick_time) > r_loop_timeout;
    assign n_bus_rst   = r_item.bus_active && (r_busy_since != 32'd0)
                         && ((r_item.now_ms - r_busy_since) > r_bus_stall);
    assign n_stale     = r_item.link_connected
                         && ((r_item.now_ms - r_publish_time) > r_publish_stale);

    // flood test as (errors + bus reset)*100 >= (percent+1)*transactions, no divide needed
    assign err_total   = {1'b0, r_item.errors} + {32'd0, n_bus_rst};
    assign flood_plus1 = {1'b0, r_flood_percent} + 8'd1;
    assign n_err_prod  = PROD_W'(err_total) * PROD_W'(PCT_SCALE);
    assign n_thr_prod  = PROD_W'(flood_plus1) * PROD_W'(r_item.transactions);

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_loop_fail <= n_loop_fail;
            r_bus_rst   <= n_bus_rst;
            r_stale     <= n_stale;
            r_trans_gt  <= r_item.transactions > r_min_trans;
            r_recent    <= (r_item.last_error_ms != 32'd0)
                           && ((r_item.now_ms - r_item.last_error_ms) < r_recent_error);
            r_heap_low  <= r_item.heap_free < r_heap_warn;
            r_err_prod  <= n_err_prod;
            r_thr_prod  <= n_thr_prod;
        end
    end

    assign flood = r_trans_gt && r_recent && (r_err_prod >= r_thr_prod);

    // state update and result on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled      <= 1'b0;
            r_kick_time    <= 32'd0;
            r_publish_time <= 32'd0;
            r_busy_since   <= 32'd0;
            r_reboot_count <= 32'd0;
        end else if (i_cmd.commit) begin
            unique case (r_item.operation)
                OP_INIT: begin
                    r_reboot_count <= r_item.stored_reboots;
                    r_kick_time    <= r_item.now_ms;
                    r_publish_time <= r_item.now_ms;
                    r_enabled      <= 1'b1;
                end
                OP_KICK:    r_kick_time    <= r_item.now_ms;
                OP_PUBLISH: r_publish_time <= r_item.now_ms;
                OP_CHECK: begin
                    if (r_enabled) begin
                        if (r_loop_fail) begin
                            r_reboot_count <= r_reboot_count + 32'd1;
                        end else begin
                            if (!r_item.bus_active || r_bus_rst) begin
                                r_busy_since <= 32'd0;
                            end else if (r_busy_since == 32'd0) begin
                                r_busy_since <= r_item.now_ms;
                            end
                            if (r_stale) begin
                                r_publish_time <= r_item.now_ms;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // result of the committed item
    always_comb begin
        n_result              = '0;
        n_result.reboot_total = r_reboot_count;
        unique case (r_item.operation)
            OP_INIT: n_result.reboot_total = r_item.stored_reboots;
            OP_CHECK: begin
                if (r_enabled && r_loop_fail) begin
                    n_result.reboot_request = 1'b1;
                    n_result.reboot_total   = r_reboot_count + 32'd1;
                end else if (r_enabled) begin
                    n_result.bus_reset      = r_bus_rst;
                    n_result.link_reconnect = r_stale;
                    n_result.error_flood    = flood;
                    n_result.heap_low       = r_heap_low;
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_result <= n_result;
        end
    end

endmodule

// ----- src/hmw_checker.sv -----
// port-level checker of the health monitor watchdog and its bind
module hmw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_reboot_request,
    input logic        i_bus_reset,
    input logic        i_link_reconnect,
    input logic        i_error_flood,
    input logic        i_heap_low,
    input logic [31:0] i_reboot_total
);

    logic in_xfer;
    assign in_xfer = i_in_valid && i_in_ready;

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_out_valid && !i_out_ready) |-> i_out_valid && $stable(i_reboot_total)
            && $stable(i_reboot_request) && $stable(i_error_flood))
        else $error("result changed while stalled");

    // one item in flight: no transfer right after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !i_in_ready)
        else $error("input accepted while an item is in flight");

    // a reboot request ends the check, no other flag
    a_reboot_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_reboot_request |-> !i_bus_reset && !i_link_reconnect
            && !i_error_flood && !i_heap_low)
        else $error("flags raised with a reboot request");

    // a fresh result follows a matching input transfer
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(in_xfer, 2) || $past(in_xfer, 3))
        else $error("result without a matching input transfer");

endmodule

bind health_monitor_watchdog hmw_checker u_hmw_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_reboot_request (o_out.reboot_request),
    .i_bus_reset      (o_out.bus_reset),
    .i_link_reconnect (o_out.link_reconnect),
    .i_error_flood    (o_out.error_flood),
    .i_heap_low       (o_out.heap_low),
    .i_reboot_total   (o_out.reboot_total)
);
